### src/kli_pkg.sv
package kli_pkg;

  localparam int TIME_W    = 32;
  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 16;
  // fraction runs from 0 to 1.0 inclusive, so one integer bit
  localparam int T_W       = FRAC_W + 1;
  localparam int KEY_W     = TIME_W + 3 * VAL_W;
  localparam int DIV_CNT_W = $clog2(T_W);
  localparam int DIFF_W    = VAL_W + 1;
  localparam int PROD_W    = DIFF_W + T_W + 1;
  localparam int QUOT_W    = PROD_W - FRAC_W;
  localparam int SUM_W     = QUOT_W + 1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_ZERO,
    RES_KEY,
    RES_MIX
  } res_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_FIRST,
    S_SCAN,
    S_DIV,
    S_MUL,
    S_ACC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    wr_key;
    logic    clr_keys;
    logic    rd_rst;
    logic    rd_adv;
    logic    prev_load;
    logic    div_start;
    logic    div_step;
    logic    mul_en;
    logic    comp_adv;
    res_op_t res_op;
    status_t res_status;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t op;
    logic count_zero;
    logic count_one;
    logic count_full;
    logic tq_le_first;
    logic hit;
    logic at_last;
    logic div_last;
    logic comp_last;
    logic out_free;
  } dp_sts_t;

endpackage

### src/kli_ram.sv
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/kli_ctrl.sv
module kli_ctrl import kli_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t dp_cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    dp_cmd            = '0;
    dp_cmd.res_op     = RES_HOLD;
    dp_cmd.res_status = ST_OK;
    in_ready          = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.latch_in = 1'b1;
          state_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next    = S_FIN;
        dp_cmd.res_op = RES_ZERO;
        unique case (sts.op)
          CMD_LOAD: begin
            if (sts.count_full) begin
              dp_cmd.res_status = ST_FULL;
            end else begin
              dp_cmd.wr_key = 1'b1;
            end
          end
          CMD_CLEAR: begin
            dp_cmd.clr_keys = 1'b1;
          end
          CMD_QUERY: begin
            if (sts.count_zero) begin
              dp_cmd.res_status = ST_EMPTY;
            end else begin
              dp_cmd.res_op = RES_HOLD;
              dp_cmd.rd_rst = 1'b1;
              state_next    = S_FETCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_FETCH: begin
        dp_cmd.rd_adv = 1'b1;
        state_next    = S_FIRST;
      end
      S_FIRST: begin
        // at or before the first key, or a single key: first key's value
        if (sts.count_one || sts.tq_le_first) begin
          dp_cmd.res_op = RES_KEY;
          state_next    = S_FIN;
        end else begin
          dp_cmd.prev_load = 1'b1;
          dp_cmd.rd_adv    = 1'b1;
          state_next       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          dp_cmd.div_start = 1'b1;
          state_next       = S_DIV;
        end else if (sts.at_last) begin
          dp_cmd.res_op = RES_KEY;
          state_next    = S_FIN;
        end else begin
          dp_cmd.prev_load = 1'b1;
          dp_cmd.rd_adv    = 1'b1;
        end
      end
      S_DIV: begin
        dp_cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        dp_cmd.mul_en = 1'b1;
        state_next    = S_ACC;
      end
      S_ACC: begin
        dp_cmd.res_op   = RES_MIX;
        dp_cmd.comp_adv = 1'b1;
        state_next      = sts.comp_last ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (sts.out_free) begin
          dp_cmd.out_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/kli_dp.sv
module kli_dp import kli_pkg::*; #(
  parameter int MAX_KEYS = 64,
  localparam int AW = $clog2(MAX_KEYS),
  localparam int CW = $clog2(MAX_KEYS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 dp_cmd,
  output dp_sts_t                 sts,
  input  logic [1:0]              cmd,
  input  logic [TIME_W-1:0]       time_point,
  input  logic signed [VAL_W-1:0] key_x,
  input  logic signed [VAL_W-1:0] key_y,
  input  logic signed [VAL_W-1:0] key_z,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] out_x,
  output logic signed [VAL_W-1:0] out_y,
  output logic signed [VAL_W-1:0] out_z
);

  cmd_t                  op;
  logic [TIME_W-1:0]     t_query;
  logic [VAL_W-1:0]      load_x, load_y, load_z;
  logic [CW-1:0]         key_count;
  logic [CW-1:0]         rd_idx;
  logic [KEY_W-1:0]      rd_data;
  logic [TIME_W-1:0]     rd_t;
  logic [VAL_W-1:0]      rd_x, rd_y, rd_z;
  logic [TIME_W-1:0]     prev_t;
  logic [VAL_W-1:0]      prev_x, prev_y, prev_z;
  logic [VAL_W-1:0]      cur_x, cur_y, cur_z;
  logic [TIME_W:0]       rem;
  logic [TIME_W-1:0]     den;
  logic [T_W-1:0]        frac;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic                  rem_ge;
  logic [TIME_W:0]       rem_sub;
  logic                  q_bit;
  logic [1:0]            comp;
  logic [VAL_W-1:0]      a_sel, b_sel;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [QUOT_W-1:0] quot;
  logic signed [SUM_W-1:0]  sum;
  logic [VAL_W-1:0]      mix_sat;
  status_t               res_status;
  logic [VAL_W-1:0]      res_x, res_y, res_z;
  status_t               out_status;

  kli_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_KEYS)
  ) u_ram (
    .clk  (clk),
    .we   (dp_cmd.wr_key),
    .waddr(key_count[AW-1:0]),
    .wdata({t_query, load_x, load_y, load_z}),
    .raddr(rd_idx[AW-1:0]),
    .rdata(rd_data)
  );

  assign rd_t = rd_data[KEY_W-1 -: TIME_W];
  assign rd_x = rd_data[3*VAL_W-1 -: VAL_W];
  assign rd_y = rd_data[2*VAL_W-1 -: VAL_W];
  assign rd_z = rd_data[VAL_W-1:0];

  // request fields
  always_ff @(posedge clk) begin
    if (dp_cmd.latch_in) begin
      op      <= cmd_t'(cmd);
      t_query <= time_point;
      load_x  <= key_x;
      load_y  <= key_y;
      load_z  <= key_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (dp_cmd.clr_keys) begin
      key_count <= '0;
    end else if (dp_cmd.wr_key) begin
      key_count <= key_count + CW'(1);
    end
  end

  // rd_idx is one ahead of the entry on rd_data while scanning
  always_ff @(posedge clk) begin
    if (dp_cmd.rd_rst) begin
      rd_idx <= '0;
    end else if (dp_cmd.rd_adv) begin
      rd_idx <= rd_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.prev_load) begin
      prev_t <= rd_t;
      prev_x <= rd_x;
      prev_y <= rd_y;
      prev_z <= rd_z;
    end
    if (dp_cmd.div_start) begin
      cur_x <= rd_x;
      cur_y <= rd_y;
      cur_z <= rd_z;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_ge  = rem >= {1'b0, den};
  assign rem_sub = rem_ge ? rem - {1'b0, den} : rem;
  assign q_bit   = rem_ge && (den != '0);

  always_ff @(posedge clk) begin
    if (dp_cmd.div_start) begin
      den     <= rd_t - prev_t;
      rem     <= {1'b0, t_query - prev_t};
      frac    <= '0;
      div_cnt <= '0;
    end else if (dp_cmd.div_step) begin
      rem     <= {rem_sub[TIME_W-1:0], 1'b0};
      frac    <= {frac[T_W-2:0], q_bit};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_comb begin
    case (comp)
      2'd0:    begin a_sel = prev_x; b_sel = cur_x; end
      2'd1:    begin a_sel = prev_y; b_sel = cur_y; end
      default: begin a_sel = prev_z; b_sel = cur_z; end
    endcase
  end

  assign diff = $signed({b_sel[VAL_W-1], b_sel}) - $signed({a_sel[VAL_W-1], a_sel});

  always_ff @(posedge clk) begin
    if (dp_cmd.div_start) begin
      comp <= 2'd0;
    end else if (dp_cmd.comp_adv) begin
      comp <= comp + 2'd1;
    end
    if (dp_cmd.mul_en) begin
      prod <= diff * $signed({1'b0, frac});
    end
  end

  // arithmetic shift floors toward minus infinity
  assign quot = prod[PROD_W-1:FRAC_W];
  assign sum  = $signed({{(SUM_W-VAL_W){a_sel[VAL_W-1]}}, a_sel})
              + $signed({quot[QUOT_W-1], quot});

  always_comb begin
    if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1) begin
      mix_sat = sum[VAL_W-1:0];
    end else if (sum[SUM_W-1]) begin
      mix_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      mix_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.res_op)
      RES_ZERO: begin
        res_status <= dp_cmd.res_status;
        res_x      <= '0;
        res_y      <= '0;
        res_z      <= '0;
      end
      RES_KEY: begin
        res_status <= ST_OK;
        res_x      <= rd_x;
        res_y      <= rd_y;
        res_z      <= rd_z;
      end
      RES_MIX: begin
        res_status <= ST_OK;
        case (comp)
          2'd0:    res_x <= mix_sat;
          2'd1:    res_y <= mix_sat;
          default: res_z <= mix_sat;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.out_load) begin
      out_status <= res_status;
      out_x      <= res_x;
      out_y      <= res_y;
      out_z      <= res_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status = out_status;

  assign sts.op          = op;
  assign sts.count_zero  = key_count == '0;
  assign sts.count_one   = key_count == CW'(1);
  assign sts.count_full  = key_count == CW'(MAX_KEYS);
  assign sts.tq_le_first = t_query <= rd_t;
  assign sts.hit         = (prev_t <= t_query) && (t_query <= rd_t);
  assign sts.at_last     = rd_idx == key_count;
  assign sts.div_last    = div_cnt == DIV_CNT_W'(T_W - 1);
  assign sts.comp_last   = comp == 2'd2;
  assign sts.out_free    = !out_valid || out_ready;

endmodule

### src/keyframe_linear_interpolator.sv
// keyframe table with piecewise linear lookup of a three-component vector
// input channel (in_valid/in_ready): cmd selects load key, query at time_point,
//   or clear; load appends {time_point, key_x, key_y, key_z} at the table end
// output channel (out_valid/out_ready): one result per request, status plus
//   out_x/out_y/out_z, zero except for a query on a non-empty table
// sequence: load, clear and unused codes go from S_EXEC to S_FIN; a query reads
//   the first key (S_FETCH, S_FIRST), scans pairs in S_SCAN, divides in S_DIV
//   and runs S_MUL, S_ACC per component, or takes a key's value, then S_FIN
// throughput: one request at a time; the next request is accepted the cycle
//   after the previous result is written to the output register
// the query time is set by a linear scan of the key memory (one read port,
//   one entry per cycle), a restoring divider for the fraction and
//   one shared multiplier used once per component
// reset clears the key count and the output valid; key memory is not cleared
// a stalled receiver holds the result in the output register; one more
//   request is taken and worked, then waits until the output frees up
module keyframe_linear_interpolator import kli_pkg::*; #(
  parameter int MAX_KEYS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              cmd,
  input  logic [TIME_W-1:0]       time_point,
  input  logic signed [VAL_W-1:0] key_x,
  input  logic signed [VAL_W-1:0] key_y,
  input  logic signed [VAL_W-1:0] key_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] out_x,
  output logic signed [VAL_W-1:0] out_y,
  output logic signed [VAL_W-1:0] out_z
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  kli_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (dp_sts),
    .dp_cmd  (dp_cmd)
  );

  kli_dp #(
    .MAX_KEYS(MAX_KEYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .sts       (dp_sts),
    .cmd       (cmd),
    .time_point(time_point),
    .key_x     (key_x),
    .key_y     (key_y),
    .key_z     (key_z),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.wr_key |-> !dp_sts.count_full)
    else $error("key written into a full table");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(dp_cmd.out_load))
    else $error("output valid raised without a result load");
`endif

endmodule

### tb/keyframe_linear_interpolator_tb.sv
`timescale 1ns / 100ps

module keyframe_linear_interpolator_tb;
  import kli_pkg::*;

  localparam int KEYS = 64;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam int RANDOM_REQS = 860;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    status_t                 st;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
  } kf_result_t;

  typedef struct {
    cmd_t              op;
    logic [TIME_W-1:0] tp;
    logic [VAL_W-1:0]  kx;
    logic [VAL_W-1:0]  ky;
    logic [VAL_W-1:0]  kz;
    bit                fill;
    bit                fixed;
    kf_result_t        res;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  cmd_t                    cmd = CMD_NOP;
  logic [TIME_W-1:0]       time_point = '0;
  logic signed [VAL_W-1:0] key_x = '0;
  logic signed [VAL_W-1:0] key_y = '0;
  logic signed [VAL_W-1:0] key_z = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] out_x;
  logic signed [VAL_W-1:0] out_y;
  logic signed [VAL_W-1:0] out_z;

  // shadow key table
  int                      kf_count = 0;
  logic [TIME_W-1:0]       kf_times [KEYS];
  logic signed [VAL_W-1:0] kf_x [KEYS];
  logic signed [VAL_W-1:0] kf_y [KEYS];
  logic signed [VAL_W-1:0] kf_z [KEYS];

  kf_result_t due_results [$];
  dir_row_t   dir_rows [$];

  int burst_left = 0;
  int sent_count = 0;
  int checked_count = 0;
  int fail_count = 0;
  int n_loads = 0, n_drops = 0, n_clears = 0;
  int n_queries = 0, n_empty = 0, n_mix = 0, n_last = 0;

  keyframe_linear_interpolator #(.MAX_KEYS(KEYS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .time_point (time_point),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a + floor((b - a) * frac / 1.0), clamped to the value range
  function automatic logic signed [VAL_W-1:0] lerp_comp(logic signed [VAL_W-1:0] a,
                                                        logic signed [VAL_W-1:0] b,
                                                        logic [63:0] frac);
    longint span;
    longint r;
    span = (longint'(b) - longint'(a)) * longint'(frac);
    r = longint'(a) + (span >>> FRAC_W);
    if (r > VAL_MAX) r = VAL_MAX;
    if (r < VAL_MIN) r = VAL_MIN;
    return r[VAL_W-1:0];
  endfunction

  function automatic kf_result_t keyframe_step(cmd_t op, logic [TIME_W-1:0] tq,
                                               logic [VAL_W-1:0] kx, ky, kz);
    kf_result_t r;
    logic [63:0] num, den, frac;
    int last;
    int i;
    bit hit;
    r = '0;
    case (op)
      CMD_LOAD: begin
        if (kf_count < KEYS) begin
          kf_times[kf_count] = tq;
          kf_x[kf_count] = kx;
          kf_y[kf_count] = ky;
          kf_z[kf_count] = kz;
          kf_count++;
          n_loads++;
        end else begin
          r.st = ST_FULL;
          n_drops++;
        end
      end
      CMD_CLEAR: begin
        kf_count = 0;
        n_clears++;
      end
      CMD_QUERY: begin
        n_queries++;
        if (kf_count == 0) begin
          r.st = ST_EMPTY;
          n_empty++;
        end else if (kf_count == 1 || tq <= kf_times[0]) begin
          r.x = kf_x[0];
          r.y = kf_y[0];
          r.z = kf_z[0];
        end else begin
          last = kf_count - 1;
          hit = 1'b0;
          for (i = 0; i < last && !hit; i++) begin
            if (kf_times[i] <= tq && tq <= kf_times[i+1]) begin
              den = {32'd0, kf_times[i+1] - kf_times[i]};
              num = {32'd0, tq - kf_times[i]} << FRAC_W;
              // coincident keys give the earlier one
              frac = (den != 0) ? num / den : 64'd0;
              r.x = lerp_comp(kf_x[i], kf_x[i+1], frac);
              r.y = lerp_comp(kf_y[i], kf_y[i+1], frac);
              r.z = lerp_comp(kf_z[i], kf_z[i+1], frac);
              hit = 1'b1;
              n_mix++;
            end
          end
          if (!hit) begin
            r.x = kf_x[last];
            r.y = kf_y[last];
            r.z = kf_z[last];
            n_last++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_query_time();
    logic [TIME_W-1:0] lo, hi, kt;
    int j;
    if (kf_count == 0) return $urandom;
    j = $urandom_range(0, kf_count - 1);
    kt = kf_times[j];
    lo = kf_times[0];
    hi = kf_times[kf_count-1];
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return kt;
      2: return kt + 1;
      3: return kt - 1;
      4: return $urandom_range(0, lo);
      5: return $urandom_range(hi, 32'hFFFF_FFFF);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic void add_row(cmd_t op, logic [TIME_W-1:0] tp,
                                  logic [VAL_W-1:0] kx, ky, kz, bit fill, bit fixed,
                                  status_t st, logic [VAL_W-1:0] rx, ry, rz);
    dir_row_t row;
    row.op = op;
    row.tp = tp;
    row.kx = kx;
    row.ky = ky;
    row.kz = kz;
    row.fill = fill;
    row.fixed = fixed;
    row.res.st = st;
    row.res.x = rx;
    row.res.y = ry;
    row.res.z = rz;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // one request through the input handshake, sender idles between bursts
  task automatic send_req(input cmd_t op, input logic [TIME_W-1:0] tp,
                          input logic [VAL_W-1:0] kx, ky, kz,
                          input bit fixed, input kf_result_t fixed_res);
    kf_result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= op;
    time_point <= tp;
    key_x <= kx;
    key_y <= ky;
    key_z <= kz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = keyframe_step(op, tp, kx, ky, kz);
    due_results.insert(due_results.size(), fixed ? fixed_res : r);
    if (op != CMD_NOP) sent_count++;
    @(negedge clk);
  endtask

  // receiver stall pattern, switching to a randomly chosen mode whenever its run ends
  int sink_mode = 0;
  int sink_left = 0;
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(20, 200);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (sink_left % 16 < 11);
    endcase
  end

  always @(posedge clk) begin
    kf_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result with no pending request: st=%0d x=%h y=%h z=%h",
                   status, out_x, out_y, out_z);
      end else begin
        want = due_results.pop_front();
        checked_count++;
        if (status !== want.st || out_x !== want.x || out_y !== want.y ||
            out_z !== want.z) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch on result %0d: expected st=%0d x=%h y=%h z=%h, %s",
                     checked_count, want.st, want.x, want.y, want.z,
                     $sformatf("got st=%0d x=%h y=%h z=%h", status, out_x, out_y, out_z));
        end
      end
    end
  end

  initial begin
    int base;
    int nk, nq, kind;
    logic [TIME_W-1:0] tcur, step;
    logic [TIME_W:0] tnext;

    // directed: extremes, every command, empty/single/full table, out-of-order keys
    add_row(CMD_QUERY, 32'h0000_0000, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0);
    add_row(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            0, 1, ST_OK, 0, 0, 0);
    add_row(CMD_CLEAR, 32'h0000_0000, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0);
    add_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0);
    add_row(CMD_LOAD, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0,
            0, 1, ST_OK, 0, 0, 0);
    add_row(CMD_QUERY, 32'h0000_0000, 0, 0, 0,
            0, 1, ST_OK, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    add_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0,
            0, 1, ST_OK, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    add_row(CMD_LOAD, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
            0, 1, ST_OK, 0, 0, 0);
    add_row(CMD_QUERY, 32'h0002_0000, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_QUERY, 32'h0002_8001, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_QUERY, 32'h0003_0000, 0, 0, 0,
            0, 1, ST_OK, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
    add_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0,
            0, 1, ST_OK, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
    // second key at the same time
    add_row(CMD_LOAD, 32'h0003_0000, 1, 2, 3, 0, 1, ST_OK, 0, 0, 0);
    add_row(CMD_QUERY, 32'h0003_0000, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_CLEAR, 32'h0000_0000, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0);
    // descending keys: no bracketing pair above the first key
    add_row(CMD_LOAD, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
            0, 1, ST_OK, 0, 0, 0);
    add_row(CMD_LOAD, 32'h0002_0000, 2, 4, 6, 0, 1, ST_OK, 0, 0, 0);
    add_row(CMD_LOAD, 32'h0001_0000, 32'h7FFF_0000, 32'h8000_0001, 32'hDEAD_BEEF,
            0, 1, ST_OK, 0, 0, 0);
    add_row(CMD_QUERY, 32'h0006_0000, 0, 0, 0,
            0, 1, ST_OK, 32'h7FFF_0000, 32'h8000_0001, 32'hDEAD_BEEF);
    add_row(CMD_QUERY, 32'h0005_0000, 0, 0, 0,
            0, 1, ST_OK, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678);
    add_row(CMD_CLEAR, 32'h0000_0000, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0);
    // table filled first, then one load too many
    add_row(CMD_LOAD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
            1, 1, ST_FULL, 0, 0, 0);
    add_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_QUERY, 32'h4100_0000, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_CLEAR, 32'h0000_0000, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].fill) begin
        while (kf_count < KEYS)
          send_req(CMD_LOAD, kf_count * 32'h0200_0000 + $urandom_range(0, 32'h00FF_FFFF),
                   pick_value(), pick_value(), pick_value(), 1'b0, '0);
      end
      send_req(dir_rows[i].op, dir_rows[i].tp, dir_rows[i].kx, dir_rows[i].ky,
               dir_rows[i].kz, dir_rows[i].fixed, dir_rows[i].res);
    end

    base = sent_count;
    while (sent_count - base < RANDOM_REQS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // sorted key set, then queries around it
        send_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
        nk = ($urandom_range(0, 9) == 0) ? $urandom_range(40, KEYS + 4)
                                         : $urandom_range(1, 8);
        tcur = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 32'h0100_0000);
        repeat (nk) begin
          send_req(CMD_LOAD, tcur, pick_value(), pick_value(), pick_value(), 1'b0, '0);
          case ($urandom_range(0, 7))
            0: step = 32'd0;
            1, 2: step = $urandom_range(1, 256);
            3, 4, 5: step = $urandom_range(1, 32'h0010_0000);
            default: step = $urandom_range(1, 32'h0400_0000);
          endcase
          tnext = {1'b0, tcur} + step;
          tcur = tnext[TIME_W] ? 32'hFFFF_FFFF : tnext[TIME_W-1:0];
        end
        nq = $urandom_range(1, 10);
        repeat (nq)
          send_req(CMD_QUERY, pick_query_time(), $urandom, $urandom, $urandom, 1'b0, '0);
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 6))
          send_req(cmd_t'($urandom_range(0, 3)), $urandom, pick_value(), pick_value(),
                   pick_value(), 1'b0, '0);
      end else if (kind == 8) begin
        // unsorted keys appended to whatever is stored
        repeat ($urandom_range(1, 6))
          send_req(CMD_LOAD, $urandom, pick_value(), pick_value(), pick_value(), 1'b0, '0);
        repeat ($urandom_range(1, 4))
          send_req(CMD_QUERY, pick_query_time(), $urandom, $urandom, $urandom, 1'b0, '0);
      end else begin
        send_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
        send_req(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
        send_req(CMD_LOAD, $urandom, pick_value(), pick_value(), pick_value(), 1'b0, '0);
        send_req(CMD_QUERY, pick_query_time(), $urandom, $urandom, $urandom, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d loads (%0d dropped on a full table), %0d clears, %0d queries",
             sent_count, n_loads, n_drops, n_clears, n_queries);
    $display("queries: %0d interpolated, %0d past the keys, %0d on an empty table; %0d checked",
             n_mix, n_last, n_empty, checked_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
